>>> sv/mlrq_pkg.sv
// Shared types, constants and controller commands of the multilevel ready-queue scheduler.
package mlrq_pkg;

	localparam int DEF_LEVELS = 32;
	localparam int DEF_TASKS  = 64;

	localparam int KIND_W   = 3;
	localparam int TASK_W   = 6;
	localparam int PRIO_W   = 5;
	localparam int STATUS_W = 2;
	localparam int MOVED_W  = 5;
	localparam int CNT_W    = 7;

	localparam logic [CNT_W-1:0] MAX_ACTIVE_RST = 7'd32;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

	typedef enum logic [KIND_W-1:0] {
		K_ADMIT    = 3'd0,
		K_DISPATCH = 3'd1,
		K_REQUEUE  = 3'd2,
		K_BOOST    = 3'd3,
		K_RETIRE   = 3'd4
	} kind_t;

	typedef enum logic [4:0] {
		U_NOP,
		U_LATCH,
		U_ADM_RD,
		U_ADM_ID,
		U_REFUSE,
		U_DSP_RD,
		U_EMPTY,
		U_RQ_RD,
		U_RQ_LVL,
		U_RET,
		U_APP_RD,
		U_APP_WR,
		U_POP_HT,
		U_POP_NX,
		U_DSP_END,
		U_BST_INIT,
		U_BST_POP,
		U_BST_SKIP,
		U_LOAD_OUT
	} uop_t;

	typedef struct packed {
		uop_t uop;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  admit_ok;
		logic  any_ready;
		logic  task_ok;
		logic  retire_ok;
		logic  same;
		logic  scan_done;
		logic  scan_ne;
	} stat_t;

endpackage

>>> sv/mlrq_if.sv
// Request and result channel interfaces of the scheduler.
interface mlrq_req_if;
	logic                        valid;
	logic                        ready;
	logic [mlrq_pkg::KIND_W-1:0] kind;
	logic [mlrq_pkg::TASK_W-1:0] task_id;
	logic [mlrq_pkg::PRIO_W-1:0] priority_req;

	modport source (output valid, kind, task_id, priority_req, input ready);
	modport sink (input valid, kind, task_id, priority_req, output ready);
endinterface

interface mlrq_res_if;
	logic                          valid;
	logic                          ready;
	logic [mlrq_pkg::STATUS_W-1:0] status;
	logic [mlrq_pkg::TASK_W-1:0]   out_task;
	logic [mlrq_pkg::PRIO_W-1:0]   out_priority;
	logic                          round_robin;
	logic [mlrq_pkg::MOVED_W-1:0]  moved;

	modport source (output valid, status, out_task, out_priority, round_robin, moved,
		input ready);
	modport sink (input valid, status, out_task, out_priority, round_robin, moved,
		output ready);
endinterface

>>> sv/multilevel_ready_queue_scheduler.sv
// Multilevel ready-queue scheduler: one item at a time, each result one item per request.
// Admit takes an identifier from the pool and appends it to the tail of its level;
// requeue appends a task to the level stored for it; dispatch pops the head of the first
// non-empty level; boost moves the head of each non-empty level above the midpoint to it.
// A result is valid in the cycle the next item can be taken; a stalled result holds the next.
// Reset clears the counters, the ready flags and the pool valid bits; max_active returns to 32.
module multilevel_ready_queue_scheduler #(
	parameter int LEVELS = mlrq_pkg::DEF_LEVELS,
	parameter int TASKS  = mlrq_pkg::DEF_TASKS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [mlrq_pkg::CNT_W-1:0] cfg_wdata,
	mlrq_req_if.sink                   request,
	mlrq_res_if.source                 result
);

	mlrq_pkg::cmd_t  cmd;
	mlrq_pkg::stat_t stat;
	logic            in_ready;
	logic            out_valid;

	assign request.ready = in_ready;
	assign result.valid  = out_valid;

	mlrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(result.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mlrq_dp #(.LEVELS(LEVELS), .TASKS(TASKS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_kind        (request.kind),
		.in_task_id     (request.task_id),
		.in_priority_req(request.priority_req),
		.cmd            (cmd),
		.stat           (stat),
		.status         (result.status),
		.out_task       (result.out_task),
		.out_priority   (result.out_priority),
		.round_robin    (result.round_robin),
		.moved          (result.moved)
	);

	// Only one item is in flight: the block stops taking items right after an accept.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		request.valid && request.ready |=> !request.ready)
		else $error("request taken while an item is in flight");

	a_latch_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.uop == mlrq_pkg::U_LATCH |-> request.valid && request.ready)
		else $error("request latched without an accept");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.uop == mlrq_pkg::U_LOAD_OUT |-> !result.valid || result.ready)
		else $error("pending result overwritten");

	a_moved_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status != mlrq_pkg::ST_DONE |-> result.moved == '0)
		else $error("moved count on a failed request");

endmodule

>>> sv/mlrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mlrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/mlrq_ctrl.sv
// Sequencing state machine of the scheduler: issues one datapath command per cycle.
module mlrq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  mlrq_pkg::stat_t stat,
	output mlrq_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ADM_ID,
		S_RQ_LVL,
		S_APP_RD,
		S_APP_WR,
		S_POP_HT,
		S_POP_NX,
		S_DSP_END,
		S_BST_SCAN,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   boost;

	assign boost     = (stat.kind == mlrq_pkg::K_BOOST);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd.uop = mlrq_pkg::U_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.uop = mlrq_pkg::U_LATCH;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				case (stat.kind)
					mlrq_pkg::K_ADMIT: begin
						if (stat.admit_ok) begin
							cmd.uop = mlrq_pkg::U_ADM_RD;
							state_d = S_ADM_ID;
						end else begin
							cmd.uop = mlrq_pkg::U_REFUSE;
						end
					end
					mlrq_pkg::K_DISPATCH: begin
						if (stat.any_ready) begin
							cmd.uop = mlrq_pkg::U_DSP_RD;
							state_d = S_POP_HT;
						end else begin
							cmd.uop = mlrq_pkg::U_EMPTY;
						end
					end
					mlrq_pkg::K_REQUEUE: begin
						if (stat.task_ok) begin
							cmd.uop = mlrq_pkg::U_RQ_RD;
							state_d = S_RQ_LVL;
						end
					end
					mlrq_pkg::K_BOOST: begin
						cmd.uop = mlrq_pkg::U_BST_INIT;
						state_d = S_BST_SCAN;
					end
					mlrq_pkg::K_RETIRE: begin
						if (stat.retire_ok) begin
							cmd.uop = mlrq_pkg::U_RET;
						end
					end
					default: begin
						cmd.uop = mlrq_pkg::U_NOP;
					end
				endcase
			end
			S_ADM_ID: begin
				cmd.uop = mlrq_pkg::U_ADM_ID;
				state_d = S_APP_RD;
			end
			S_RQ_LVL: begin
				cmd.uop = mlrq_pkg::U_RQ_LVL;
				state_d = S_APP_RD;
			end
			S_APP_RD: begin
				cmd.uop = mlrq_pkg::U_APP_RD;
				state_d = S_APP_WR;
			end
			S_APP_WR: begin
				cmd.uop = mlrq_pkg::U_APP_WR;
				state_d = boost ? S_BST_SCAN : S_DONE;
			end
			S_POP_HT: begin
				cmd.uop = mlrq_pkg::U_POP_HT;
				if (!stat.same) begin
					state_d = S_POP_NX;
				end else begin
					state_d = boost ? S_APP_RD : S_DSP_END;
				end
			end
			S_POP_NX: begin
				cmd.uop = mlrq_pkg::U_POP_NX;
				state_d = boost ? S_APP_RD : S_DSP_END;
			end
			S_DSP_END: begin
				cmd.uop = mlrq_pkg::U_DSP_END;
				state_d = S_DONE;
			end
			S_BST_SCAN: begin
				if (stat.scan_done) begin
					state_d = S_DONE;
				end else if (stat.scan_ne) begin
					cmd.uop = mlrq_pkg::U_BST_POP;
					state_d = S_POP_HT;
				end else begin
					cmd.uop = mlrq_pkg::U_BST_SKIP;
				end
			end
			S_DONE: begin
				// The result register frees up in the same cycle it is taken.
				if (!out_valid_q || out_ready) begin
					cmd.uop = mlrq_pkg::U_LOAD_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.uop == mlrq_pkg::U_LOAD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/mlrq_dp.sv
// Datapath of the scheduler: list memories, identifier pool, counters and result registers.
module mlrq_dp #(
	parameter int LEVELS = mlrq_pkg::DEF_LEVELS,
	parameter int TASKS  = mlrq_pkg::DEF_TASKS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mlrq_pkg::CNT_W-1:0]    cfg_wdata,
	input  logic [mlrq_pkg::KIND_W-1:0]   in_kind,
	input  logic [mlrq_pkg::TASK_W-1:0]   in_task_id,
	input  logic [mlrq_pkg::PRIO_W-1:0]   in_priority_req,
	input  mlrq_pkg::cmd_t                cmd,
	output mlrq_pkg::stat_t               stat,
	output logic [mlrq_pkg::STATUS_W-1:0] status,
	output logic [mlrq_pkg::TASK_W-1:0]   out_task,
	output logic [mlrq_pkg::PRIO_W-1:0]   out_priority,
	output logic                          round_robin,
	output logic [mlrq_pkg::MOVED_W-1:0]  moved
);

	localparam int LVW = $clog2(LEVELS);
	localparam int IDW = $clog2(TASKS);
	localparam int PTW = $clog2(TASKS + 1);
	localparam int SCW = $clog2(LEVELS + 1);
	localparam logic [LVW-1:0] MID     = LVW'(LEVELS / 2);
	localparam logic [LVW-1:0] TOP_LVL = LVW'(LEVELS - 1);

	function automatic logic [LVW-1:0] sat_lvl(input logic [7:0] x);
		return (int'(x) >= LEVELS) ? TOP_LVL : LVW'(x);
	endfunction

	// Control state
	logic [mlrq_pkg::CNT_W-1:0] max_active_q;
	logic [mlrq_pkg::CNT_W-1:0] active_q;
	logic [PTW-1:0]             pool_top_q;
	logic [LEVELS-1:0]          nonempty_q;
	logic [TASKS-1:0]           pool_vld_q;

	// Working registers
	mlrq_pkg::kind_t             kind_q;
	logic [mlrq_pkg::TASK_W-1:0] task_q;
	logic [mlrq_pkg::PRIO_W-1:0] prio_q;
	logic [IDW-1:0]              id_q;
	logic [LVW-1:0]              app_lvl_q;
	logic [LVW-1:0]              pop_lvl_q;
	logic [SCW-1:0]              scan_q;
	logic [IDW-1:0]              pool_addr_q;
	logic                        pool_hit_q;

	logic [mlrq_pkg::STATUS_W-1:0] res_status_q;
	logic [mlrq_pkg::TASK_W-1:0]   res_task_q;
	logic [mlrq_pkg::PRIO_W-1:0]   res_prio_q;
	logic                          res_rr_q;
	logic [mlrq_pkg::MOVED_W-1:0]  res_moved_q;

	logic [mlrq_pkg::STATUS_W-1:0] status_q;
	logic [mlrq_pkg::TASK_W-1:0]   out_task_q;
	logic [mlrq_pkg::PRIO_W-1:0]   out_prio_q;
	logic                          out_rr_q;
	logic [mlrq_pkg::MOVED_W-1:0]  out_moved_q;

	// Memory ports
	logic           head_we, head_re, tail_we, tail_re;
	logic [LVW-1:0] head_waddr, head_raddr, tail_waddr, tail_raddr;
	logic [IDW-1:0] head_wdata, head_rdata, tail_wdata, tail_rdata;
	logic           nxt_we, nxt_re;
	logic [IDW-1:0] nxt_waddr, nxt_raddr, nxt_wdata, nxt_rdata;
	logic           prio_we, prio_re;
	logic [IDW-1:0] prio_waddr, prio_raddr;
	logic [LVW-1:0] prio_wdata, prio_rdata;
	logic           pool_we, pool_re;
	logic [IDW-1:0] pool_waddr, pool_raddr, pool_wdata, pool_rdata;

	// Derived values
	logic [LVW-1:0] first_lvl;
	logic [LVW-1:0] req_lvl;
	logic [LVW-1:0] dsp_lvl;
	logic [LVW-1:0] scan_lvl;
	logic [IDW-1:0] task_idx;
	logic [IDW-1:0] pool_rd_idx;
	logic [IDW-1:0] pool_wr_idx;
	logic [IDW-1:0] pool_id;
	logic           task_ok;

	assign req_lvl     = sat_lvl(8'(prio_q));
	assign dsp_lvl     = sat_lvl(8'(prio_rdata));
	assign scan_lvl    = LVW'(scan_q);
	assign task_idx    = IDW'(task_q);
	assign pool_rd_idx = IDW'(pool_top_q);
	assign pool_wr_idx = IDW'(pool_top_q - 1'b1);
	// An identifier pool entry never written since reset holds its own index.
	assign pool_id     = pool_hit_q ? pool_rdata : pool_addr_q;
	assign task_ok     = (int'(task_q) < TASKS);

	always_comb begin
		first_lvl = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				first_lvl = LVW'(i);
			end
		end
	end

	always_comb begin
		stat.kind      = kind_q;
		stat.admit_ok  = (int'(pool_top_q) < TASKS) && (active_q < max_active_q);
		stat.any_ready = |nonempty_q;
		stat.task_ok   = task_ok;
		stat.retire_ok = task_ok && (pool_top_q != '0);
		stat.same      = (head_rdata == tail_rdata);
		stat.scan_done = (int'(scan_q) >= LEVELS);
		stat.scan_ne   = nonempty_q[scan_lvl];
	end

	always_comb begin
		head_we    = 1'b0;
		head_waddr = app_lvl_q;
		head_wdata = id_q;
		head_re    = 1'b0;
		head_raddr = first_lvl;
		tail_we    = 1'b0;
		tail_waddr = app_lvl_q;
		tail_wdata = id_q;
		tail_re    = 1'b0;
		tail_raddr = first_lvl;
		nxt_we     = 1'b0;
		nxt_waddr  = tail_rdata;
		nxt_wdata  = id_q;
		nxt_re     = 1'b0;
		nxt_raddr  = head_rdata;
		prio_we    = 1'b0;
		prio_waddr = pool_id;
		prio_wdata = app_lvl_q;
		prio_re    = 1'b0;
		prio_raddr = task_idx;
		pool_we    = 1'b0;
		pool_waddr = pool_wr_idx;
		pool_wdata = task_idx;
		pool_re    = 1'b0;
		pool_raddr = pool_rd_idx;
		case (cmd.uop)
			mlrq_pkg::U_ADM_RD: begin
				pool_re = 1'b1;
			end
			mlrq_pkg::U_ADM_ID: begin
				prio_we = 1'b1;
			end
			mlrq_pkg::U_DSP_RD: begin
				head_re = 1'b1;
				tail_re = 1'b1;
			end
			mlrq_pkg::U_BST_POP: begin
				head_re    = 1'b1;
				tail_re    = 1'b1;
				head_raddr = scan_lvl;
				tail_raddr = scan_lvl;
			end
			mlrq_pkg::U_RQ_RD: begin
				prio_re = 1'b1;
			end
			mlrq_pkg::U_RET: begin
				pool_we = 1'b1;
			end
			mlrq_pkg::U_APP_RD: begin
				tail_re    = 1'b1;
				tail_raddr = app_lvl_q;
			end
			mlrq_pkg::U_APP_WR: begin
				tail_we = 1'b1;
				if (nonempty_q[app_lvl_q]) begin
					nxt_we = 1'b1;
				end else begin
					head_we = 1'b1;
				end
			end
			mlrq_pkg::U_POP_HT: begin
				prio_re    = 1'b1;
				prio_raddr = head_rdata;
				nxt_re     = (head_rdata != tail_rdata);
			end
			mlrq_pkg::U_POP_NX: begin
				head_we    = 1'b1;
				head_waddr = pop_lvl_q;
				head_wdata = nxt_rdata;
			end
			default: begin
				head_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_active_q <= mlrq_pkg::MAX_ACTIVE_RST;
			active_q     <= '0;
			pool_top_q   <= '0;
			nonempty_q   <= '0;
			pool_vld_q   <= '0;
		end else begin
			if (cfg_we) begin
				max_active_q <= cfg_wdata;
			end
			case (cmd.uop)
				mlrq_pkg::U_ADM_ID: begin
					pool_top_q <= pool_top_q + 1'b1;
					active_q   <= active_q + 1'b1;
				end
				mlrq_pkg::U_RET: begin
					pool_top_q              <= pool_top_q - 1'b1;
					pool_vld_q[pool_wr_idx] <= 1'b1;
					if (active_q != '0) begin
						active_q <= active_q - 1'b1;
					end
				end
				mlrq_pkg::U_APP_WR: begin
					nonempty_q[app_lvl_q] <= 1'b1;
				end
				mlrq_pkg::U_POP_HT: begin
					if (head_rdata == tail_rdata) begin
						nonempty_q[pop_lvl_q] <= 1'b0;
					end
				end
				default: begin
					active_q <= active_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.uop)
			mlrq_pkg::U_LATCH: begin
				kind_q       <= mlrq_pkg::kind_t'(in_kind);
				task_q       <= in_task_id;
				prio_q       <= in_priority_req;
				res_status_q <= mlrq_pkg::ST_DONE;
				res_task_q   <= '0;
				res_prio_q   <= '0;
				res_rr_q     <= 1'b0;
				res_moved_q  <= '0;
			end
			mlrq_pkg::U_ADM_RD: begin
				pool_addr_q <= pool_rd_idx;
				pool_hit_q  <= pool_vld_q[pool_rd_idx];
				app_lvl_q   <= req_lvl;
			end
			mlrq_pkg::U_ADM_ID: begin
				id_q       <= pool_id;
				res_task_q <= mlrq_pkg::TASK_W'(pool_id);
			end
			mlrq_pkg::U_REFUSE: begin
				res_status_q <= mlrq_pkg::ST_REFUSED;
			end
			mlrq_pkg::U_EMPTY: begin
				res_status_q <= mlrq_pkg::ST_EMPTY;
			end
			mlrq_pkg::U_DSP_RD: begin
				pop_lvl_q <= first_lvl;
			end
			mlrq_pkg::U_RQ_RD: begin
				id_q <= task_idx;
			end
			mlrq_pkg::U_RQ_LVL: begin
				app_lvl_q <= dsp_lvl;
			end
			mlrq_pkg::U_POP_HT: begin
				id_q <= head_rdata;
			end
			mlrq_pkg::U_DSP_END: begin
				res_task_q <= mlrq_pkg::TASK_W'(id_q);
				res_prio_q <= mlrq_pkg::PRIO_W'(dsp_lvl);
				res_rr_q   <= (dsp_lvl >= MID);
			end
			mlrq_pkg::U_BST_INIT: begin
				scan_q <= SCW'(LEVELS / 2 + 1);
			end
			mlrq_pkg::U_BST_POP: begin
				pop_lvl_q <= scan_lvl;
				app_lvl_q <= MID;
			end
			mlrq_pkg::U_BST_SKIP: begin
				scan_q <= scan_q + 1'b1;
			end
			mlrq_pkg::U_APP_WR: begin
				if (kind_q == mlrq_pkg::K_BOOST) begin
					scan_q      <= scan_q + 1'b1;
					res_moved_q <= res_moved_q + 1'b1;
				end
			end
			mlrq_pkg::U_LOAD_OUT: begin
				status_q    <= res_status_q;
				out_task_q  <= res_task_q;
				out_prio_q  <= res_prio_q;
				out_rr_q    <= res_rr_q;
				out_moved_q <= res_moved_q;
			end
			default: begin
				id_q <= id_q;
			end
		endcase
	end

	assign status       = status_q;
	assign out_task     = out_task_q;
	assign out_priority = out_prio_q;
	assign round_robin  = out_rr_q;
	assign moved        = out_moved_q;

	mlrq_ram #(.WIDTH(IDW), .DEPTH(LEVELS)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.re(head_re), .raddr(head_raddr), .rdata(head_rdata)
	);

	mlrq_ram #(.WIDTH(IDW), .DEPTH(LEVELS)) u_tail (
		.clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
		.re(tail_re), .raddr(tail_raddr), .rdata(tail_rdata)
	);

	mlrq_ram #(.WIDTH(IDW), .DEPTH(TASKS)) u_next (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.re(nxt_re), .raddr(nxt_raddr), .rdata(nxt_rdata)
	);

	mlrq_ram #(.WIDTH(LVW), .DEPTH(TASKS)) u_prio (
		.clk(clk), .we(prio_we), .waddr(prio_waddr), .wdata(prio_wdata),
		.re(prio_re), .raddr(prio_raddr), .rdata(prio_rdata)
	);

	mlrq_ram #(.WIDTH(IDW), .DEPTH(TASKS)) u_pool (
		.clk(clk), .we(pool_we), .waddr(pool_waddr), .wdata(pool_wdata),
		.re(pool_re), .raddr(pool_raddr), .rdata(pool_rdata)
	);

endmodule
